[hw/rtl/sit_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection test package
// Shared constants, coordinate and difference indexes, and orientation types.
// ----------------------------------------------------------------------------
package sit_pkg;

    // Default coordinate width.
    localparam int DEF_COORD_BITS = 16;

    // Number of input coordinates and their order on the input bus.
    localparam int NUM_COORDS = 8;
    localparam int CRD_PX = 0;
    localparam int CRD_PY = 1;
    localparam int CRD_QX = 2;
    localparam int CRD_QY = 3;
    localparam int CRD_RX = 4;
    localparam int CRD_RY = 5;
    localparam int CRD_SX = 6;
    localparam int CRD_SY = 7;

    // Coordinate differences formed in the first stage.
    localparam int NUM_DIFFS = 12;
    localparam int DIF_QP_X = 0;
    localparam int DIF_QP_Y = 1;
    localparam int DIF_RP_X = 2;
    localparam int DIF_RP_Y = 3;
    localparam int DIF_SP_X = 4;
    localparam int DIF_SP_Y = 5;
    localparam int DIF_SR_X = 6;
    localparam int DIF_SR_Y = 7;
    localparam int DIF_PR_X = 8;
    localparam int DIF_PR_Y = 9;
    localparam int DIF_QR_X = 10;
    localparam int DIF_QR_Y = 11;

    // Cross products: for each triangle a left and a right term.
    localparam int NUM_PRODS = 8;
    localparam int PRD_PQR_L = 0;
    localparam int PRD_PQR_R = 1;
    localparam int PRD_PQS_L = 2;
    localparam int PRD_PQS_R = 3;
    localparam int PRD_RSP_L = 4;
    localparam int PRD_RSP_R = 5;
    localparam int PRD_RSQ_L = 6;
    localparam int PRD_RSQ_R = 7;

    // Between tests used in the collinear case.
    localparam int NUM_BTW = 4;

    // Sign of one orientation determinant.
    typedef enum logic [1:0] {
        ORI_ZERO = 2'b00,
        ORI_POS  = 2'b01,
        ORI_NEG  = 2'b10
    } orient_t;

    // The four orientations of one segment pair.
    typedef struct packed {
        orient_t pqr;
        orient_t pqs;
        orient_t rsp;
        orient_t rsq;
    } quad_orient_t;

endpackage

[hw/rtl/sit_diff.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Difference stage
// Forms the coordinate differences of the four orientation tests and the
// endpoint between flags of the collinear case, then registers them.
// ----------------------------------------------------------------------------
module sit_diff
    import sit_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] coord [NUM_COORDS],
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS:0]   diff [NUM_DIFFS],
    output logic [NUM_BTW-1:0]           btw
);

    localparam int DW = COORD_BITS + 1;

    logic                 valid_reg;
    logic signed [DW-1:0] diff_reg  [NUM_DIFFS];
    logic signed [DW-1:0] diff_next [NUM_DIFFS];
    logic [NUM_BTW-1:0]   btw_reg;
    logic [NUM_BTW-1:0]   btw_next;

    // True when c lies between a and b, ends included.
    function automatic logic between_f(
        input logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy
    );
        logic res;
        if (ax == bx) begin
            res = (ay <= cy && by >= cy) || (ay >= cy && by <= cy);
        end else begin
            res = (ax <= cx && bx >= cx) || (ax >= cx && bx <= cx);
        end
        return res;
    endfunction

    // Differences are one bit wider than the coordinates, so none overflows.
    always_comb begin
        diff_next[DIF_QP_X] = DW'(coord[CRD_QX]) - DW'(coord[CRD_PX]);
        diff_next[DIF_QP_Y] = DW'(coord[CRD_QY]) - DW'(coord[CRD_PY]);
        diff_next[DIF_RP_X] = DW'(coord[CRD_RX]) - DW'(coord[CRD_PX]);
        diff_next[DIF_RP_Y] = DW'(coord[CRD_RY]) - DW'(coord[CRD_PY]);
        diff_next[DIF_SP_X] = DW'(coord[CRD_SX]) - DW'(coord[CRD_PX]);
        diff_next[DIF_SP_Y] = DW'(coord[CRD_SY]) - DW'(coord[CRD_PY]);
        diff_next[DIF_SR_X] = DW'(coord[CRD_SX]) - DW'(coord[CRD_RX]);
        diff_next[DIF_SR_Y] = DW'(coord[CRD_SY]) - DW'(coord[CRD_RY]);
        diff_next[DIF_PR_X] = DW'(coord[CRD_PX]) - DW'(coord[CRD_RX]);
        diff_next[DIF_PR_Y] = DW'(coord[CRD_PY]) - DW'(coord[CRD_RY]);
        diff_next[DIF_QR_X] = DW'(coord[CRD_QX]) - DW'(coord[CRD_RX]);
        diff_next[DIF_QR_Y] = DW'(coord[CRD_QY]) - DW'(coord[CRD_RY]);
    end

    // Each endpoint tested against the other segment.
    always_comb begin
        btw_next[0] = between_f(coord[CRD_PX], coord[CRD_PY], coord[CRD_QX],
                                coord[CRD_QY], coord[CRD_RX], coord[CRD_RY]);
        btw_next[1] = between_f(coord[CRD_PX], coord[CRD_PY], coord[CRD_QX],
                                coord[CRD_QY], coord[CRD_SX], coord[CRD_SY]);
        btw_next[2] = between_f(coord[CRD_RX], coord[CRD_RY], coord[CRD_SX],
                                coord[CRD_SY], coord[CRD_PX], coord[CRD_PY]);
        btw_next[3] = between_f(coord[CRD_RX], coord[CRD_RY], coord[CRD_SX],
                                coord[CRD_SY], coord[CRD_QX], coord[CRD_QY]);
    end

    // The stage takes a new request when it is empty or its content moves on.
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            diff_reg <= diff_next;
            btw_reg  <= btw_next;
        end
    end

    assign out_valid = valid_reg;
    assign diff      = diff_reg;
    assign btw       = btw_reg;

endmodule

[hw/rtl/sit_prod.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Product stage
// Multiplies the differences into the two cross terms of each determinant.
// ----------------------------------------------------------------------------
module sit_prod
    import sit_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [COORD_BITS:0]      diff [NUM_DIFFS],
    input  logic [NUM_BTW-1:0]              btw_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [2*COORD_BITS+1:0]  prod [NUM_PRODS],
    output logic [NUM_BTW-1:0]              btw_out
);

    localparam int PW = 2 * (COORD_BITS + 1);

    logic                 valid_reg;
    logic signed [PW-1:0] prod_reg  [NUM_PRODS];
    logic signed [PW-1:0] prod_next [NUM_PRODS];
    logic [NUM_BTW-1:0]   btw_reg;

    // Determinant of triangle abc is (b-a).x*(c-a).y against (b-a).y*(c-a).x.
    always_comb begin
        prod_next[PRD_PQR_L] = PW'(diff[DIF_QP_X]) * PW'(diff[DIF_RP_Y]);
        prod_next[PRD_PQR_R] = PW'(diff[DIF_QP_Y]) * PW'(diff[DIF_RP_X]);
        prod_next[PRD_PQS_L] = PW'(diff[DIF_QP_X]) * PW'(diff[DIF_SP_Y]);
        prod_next[PRD_PQS_R] = PW'(diff[DIF_QP_Y]) * PW'(diff[DIF_SP_X]);
        prod_next[PRD_RSP_L] = PW'(diff[DIF_SR_X]) * PW'(diff[DIF_PR_Y]);
        prod_next[PRD_RSP_R] = PW'(diff[DIF_SR_Y]) * PW'(diff[DIF_PR_X]);
        prod_next[PRD_RSQ_L] = PW'(diff[DIF_SR_X]) * PW'(diff[DIF_QR_Y]);
        prod_next[PRD_RSQ_R] = PW'(diff[DIF_SR_Y]) * PW'(diff[DIF_QR_X]);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            prod_reg <= prod_next;
            btw_reg  <= btw_in;
        end
    end

    assign out_valid = valid_reg;
    assign prod      = prod_reg;
    assign btw_out   = btw_reg;

endmodule

[hw/rtl/sit_sign.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sign stage
// Compares the cross terms and registers the sign of each determinant.
// ----------------------------------------------------------------------------
module sit_sign
    import sit_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [2*COORD_BITS+1:0]  prod [NUM_PRODS],
    input  logic [NUM_BTW-1:0]              btw_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output quad_orient_t                    orient,
    output logic [NUM_BTW-1:0]              btw_out
);

    localparam int PW = 2 * (COORD_BITS + 1);

    logic               valid_reg;
    quad_orient_t       orient_reg;
    quad_orient_t       orient_next;
    logic [NUM_BTW-1:0] btw_reg;

    function automatic orient_t cmp_f(input logic signed [PW-1:0] lhs, rhs);
        orient_t res;
        if (lhs > rhs) begin
            res = ORI_POS;
        end else if (lhs < rhs) begin
            res = ORI_NEG;
        end else begin
            res = ORI_ZERO;
        end
        return res;
    endfunction

    // One compare per determinant.
    always_comb begin
        orient_next.pqr = cmp_f(prod[PRD_PQR_L], prod[PRD_PQR_R]);
        orient_next.pqs = cmp_f(prod[PRD_PQS_L], prod[PRD_PQS_R]);
        orient_next.rsp = cmp_f(prod[PRD_RSP_L], prod[PRD_RSP_R]);
        orient_next.rsq = cmp_f(prod[PRD_RSQ_L], prod[PRD_RSQ_R]);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            orient_reg <= orient_next;
            btw_reg    <= btw_in;
        end
    end

    assign out_valid = valid_reg;
    assign orient    = orient_reg;
    assign btw_out   = btw_reg;

endmodule

[hw/rtl/sit_decide.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decision stage
// Combines the four signs and the between flags into the hit result and
// holds it in the output register.
// ----------------------------------------------------------------------------
module sit_decide
    import sit_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  quad_orient_t       orient,
    input  logic [NUM_BTW-1:0] btw,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit
);

    logic valid_reg;
    logic hit_reg;
    logic hit_next;
    logic all_zero;
    logic any_zero;

    // Collinear when every sign is zero, touching when only some are.
    always_comb begin
        all_zero = (orient.pqr == ORI_ZERO) && (orient.pqs == ORI_ZERO) &&
                   (orient.rsp == ORI_ZERO) && (orient.rsq == ORI_ZERO);
        any_zero = (orient.pqr == ORI_ZERO) || (orient.pqs == ORI_ZERO) ||
                   (orient.rsp == ORI_ZERO) || (orient.rsq == ORI_ZERO);
        priority if (all_zero) begin
            hit_next = |btw;
        end else if (any_zero) begin
            hit_next = 1'b0;
        end else begin
            hit_next = (orient.pqr != orient.pqs) && (orient.rsp != orient.rsq);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            hit_reg <= hit_next;
        end
    end

    assign out_valid = valid_reg;
    assign hit       = hit_reg;

endmodule

[hw/rtl/segment_intersection_test_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection test unit
// Decides whether segment PQ and segment RS intersect, with touching
// configurations counted as no hit unless the segments are collinear.
//
// Usage:
//   The slave channel carries one segment pair per request on s_tdata. The
//   master channel returns one request per pair with the hit flag in bit 0.
//   Results leave in the order the pairs arrived.
// Pipeline and throughput:
//   Four register stages: differences, products, compares, decision. A pair
//   accepted into the difference register passes the product, compare and
//   decision registers in that order before it raises m_tvalid. While the
//   master side does not stall, one pair is accepted every cycle; the rate
//   is set by the single multiplier bank in the product stage, which takes
//   a new pair each cycle.
// Reset:
//   A synchronous low on aresetn empties every stage; no result is pending
//   afterwards.
// Stalls:
//   When m_tready is low the result is held and the stages fill up behind
//   it; s_tready drops once all four are full. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module segment_intersection_test_unit
    import sit_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // p_x, p_y, q_x, q_y, r_x, r_y, s_x, s_y, each COORD_BITS wide
    input  logic [NUM_COORDS*COORD_BITS-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // hit in bit 0, zeros above
    output logic [7:0]                     m_tdata
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic signed [COORD_BITS-1:0] coord [NUM_COORDS];
    logic signed [DW-1:0]         diff  [NUM_DIFFS];
    logic signed [PW-1:0]         prod  [NUM_PRODS];
    logic [NUM_BTW-1:0]           btw_d;
    logic [NUM_BTW-1:0]           btw_p;
    logic [NUM_BTW-1:0]           btw_s;
    quad_orient_t                 orient;
    logic                         diff_valid, diff_ready;
    logic                         prod_valid, prod_ready;
    logic                         sign_valid, sign_ready;
    logic                         hit;

    // Unpack the coordinates from the request, first field lowest.
    always_comb begin
        for (int i = 0; i < NUM_COORDS; i++) begin
            coord[i] = s_tdata[i*COORD_BITS +: COORD_BITS];
        end
    end

    sit_diff #(
        .COORD_BITS (COORD_BITS)
    ) u_diff (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .coord     (coord),
        .out_valid (diff_valid),
        .out_ready (diff_ready),
        .diff      (diff),
        .btw       (btw_d)
    );

    sit_prod #(
        .COORD_BITS (COORD_BITS)
    ) u_prod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (diff_valid),
        .in_ready  (diff_ready),
        .diff      (diff),
        .btw_in    (btw_d),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .prod      (prod),
        .btw_out   (btw_p)
    );

    sit_sign #(
        .COORD_BITS (COORD_BITS)
    ) u_sign (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .prod      (prod),
        .btw_in    (btw_p),
        .out_valid (sign_valid),
        .out_ready (sign_ready),
        .orient    (orient),
        .btw_out   (btw_s)
    );

    sit_decide u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sign_valid),
        .in_ready  (sign_ready),
        .orient    (orient),
        .btw       (btw_s),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .hit       (hit)
    );

    assign m_tdata = {7'b0, hit};

endmodule

[hw/rtl/sit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection test checker
// Port-level assertions on the result channel and the pipeline back pressure.
// ----------------------------------------------------------------------------
module sit_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    // A stalled result keeps its value.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result value changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending right after reset");

    // When the master side takes results, every stage can move on.
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled although output is ready");

    // Only bit 0 carries the result.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:1] == 7'b0))
        else $error("padding bits of result are not zero");

endmodule

bind segment_intersection_test_unit sit_checker u_sit_checker (.*);
